// ----- hdl/palette_nearest_color_engine_top_assert.svh -----
// Assertion macros for the palette search engine.
// Bodies use the enclosing module's clk and arst_n.
`ifndef PALETTE_NEAREST_COLOR_ENGINE_TOP_ASSERT_SVH
`define PALETTE_NEAREST_COLOR_ENGINE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PNCE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pnce assertion failed");
`define PNCE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pnce assertion failed");
`else
`define PNCE_ASSERT_NOW(label, ante, cons)
`define PNCE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/pnce_pkg.sv -----
`timescale 1ns / 1ps
package pnce_pkg;

	localparam int IN_W   = 32;
	localparam int OUT_W  = 24;
	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [15:0] RED_MASK   = 16'hF800;
	localparam logic [15:0] GREEN_MASK = 16'h07E0;
	localparam logic [15:0] BLUE_MASK  = 16'h001F;
	localparam int STORE_DEPTH = 256;

	typedef enum logic [1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_SEARCH = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_SEARCH,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic wr;
		logic rd_issue;
		logic rd_use_cnt;
		logic cnt_clr;
		logic cnt_inc;
		logic best_clr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic cnt_last;
		logic out_full;
	} sts_t;

	function automatic logic [15:0] sq_diff(logic [7:0] a, logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return 16'(d) * 16'(d);
	endfunction

endpackage

// ----- hdl/pnce_ctrl.sv -----
`timescale 1ns / 1ps
module pnce_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  pnce_pkg::func_t req_func,
	input  pnce_pkg::sts_t  sts,
	output pnce_pkg::cmd_t  cmd
);
	import pnce_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					case (req_func)
						FUNC_WRITE:  state_d = ST_WRITE;
						FUNC_READ:   state_d = ST_READ;
						FUNC_SEARCH: begin
							cmd.cnt_clr  = 1'b1;
							cmd.best_clr = 1'b1;
							state_d      = ST_SEARCH;
						end
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_WRITE: begin
				cmd.wr  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_SEARCH: begin
				cmd.rd_issue   = 1'b1;
				cmd.rd_use_cnt = 1'b1;
				cmd.cnt_inc    = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hdl/pnce_dp.sv -----
`timescale 1ns / 1ps
module pnce_dp #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pnce_pkg::IN_W-1:0]   req_data,
	input  pnce_pkg::func_t             req_func,
	input  pnce_pkg::cmd_t              cmd,
	output pnce_pkg::sts_t              sts,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pnce_pkg::OUT_W-1:0]  out_data
);
	import pnce_pkg::*;

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [8:0] ENTRIES_LIM = 9'(PALETTE_ENTRIES);
	localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_ENTRIES - 1);

	// request fields
	func_t      func_q;
	logic [7:0] idx_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;

	logic [15:0]                mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] vld_q;

	logic [AW-1:0] cnt_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          idx_ok;
	logic [15:0]   wr_color;

	logic [15:0]   rd_data_s1;
	logic          rd_vld_s1;
	logic [AW-1:0] idx_s1;
	logic          v_s1;
	logic [15:0]   color_s1;
	logic [DIST_W-1:0] dist_s1;

	logic [DIST_W-1:0] dist_s2;
	logic [15:0]       color_s2;
	logic [AW-1:0]     idx_s2;
	logic              v_s2;

	logic [DIST_W-1:0] best_dist_q;
	logic [15:0]       best_color_q;
	logic [AW-1:0]     best_idx_q;

	logic              out_vld_q;
	logic [OUT_W-1:0]  out_data_q;
	logic [OUT_W-1:0]  result;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= req_func;
			idx_q   <= req_data[7:0];
			red_q   <= req_data[15:8];
			green_q <= req_data[23:16];
			blue_q  <= req_data[31:24];
		end
	end

	assign idx_ok   = {1'b0, idx_q} < ENTRIES_LIM;
	assign wr_addr  = idx_q[AW-1:0];
	assign wr_color = {red_q[7:3], green_q[7:2], blue_q[7:3]};
	assign rd_addr  = cmd.rd_use_cnt ? cnt_q : idx_q[AW-1:0];

	// palette memory, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr && idx_ok) begin
			mem[wr_addr] <= wr_color;
		end
		if (cmd.rd_issue) begin
			rd_data_s1 <= mem[rd_addr];
			rd_vld_s1  <= vld_q[rd_addr];
			idx_s1     <= rd_addr;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.wr && idx_ok) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1 <= cmd.rd_issue && cmd.rd_use_cnt;
			v_s2 <= v_s1;
		end
	end

	assign color_s1 = rd_vld_s1 ? rd_data_s1 : '0;
	assign dist_s1  = DIST_W'(sq_diff(red_q, {3'b0, color_s1[15:11]}))
		+ DIST_W'(sq_diff(green_q, {2'b0, color_s1[10:5]}))
		+ DIST_W'(sq_diff(blue_q, {3'b0, color_s1[4:0]}));

	always_ff @(posedge clk) begin
		dist_s2  <= dist_s1;
		color_s2 <= color_s1;
		idx_s2   <= idx_s1;
	end

	// strict less-than keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (cmd.best_clr) begin
			best_dist_q  <= DIST_MAX;
			best_color_q <= '0;
			best_idx_q   <= '0;
		end else if (v_s2 && (dist_s2 < best_dist_q)) begin
			best_dist_q  <= dist_s2;
			best_color_q <= color_s2;
			best_idx_q   <= idx_s2;
		end
	end

	always_comb begin
		case (func_q)
			FUNC_READ: result = {8'd0, (idx_ok ? color_s1 : 16'd0)};
			default:   result = {8'(best_idx_q), best_color_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign sts.busy     = v_s1 || v_s2;
	assign sts.cnt_last = (cnt_q == LAST_IDX);
	assign sts.out_full = out_vld_q;

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

endmodule

// ----- hdl/palette_nearest_color_engine_top.sv -----
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: index, red, green, blue; tuser: func
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: color_565, best_index
//
// Write: load the request, then write the entry. Read: load, read, then output handoff.
// Search: load, read every entry, one palette memory read per cycle, drain, then output.
// Reset clears all entries at once through per-entry valid bits; no sweep.
// A finished result sits in the output register; the next request is taken
// while it waits, but a new result is held back until that register drains.
`timescale 1ns / 1ps
`include "palette_nearest_color_engine_top_assert.svh"
module palette_nearest_color_engine_top #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // color_565[15:0], best_index[23:16]
);
	import pnce_pkg::*;

	cmd_t  cmd;
	sts_t  sts;
	func_t req_func;

	assign req_func = func_t'(s_axis_tuser);

	pnce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_func  (req_func),
		.sts       (sts),
		.cmd       (cmd)
	);

	pnce_dp #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (s_axis_tdata),
		.req_func  (req_func),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	`PNCE_ASSERT_NOW(a_load_needs_room, cmd.out_load, !sts.out_full)
	`PNCE_ASSERT_NOW(a_idle_pipe_empty, s_axis_tready, !sts.busy)
	`PNCE_ASSERT_NEXT(a_write_no_result, s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_WRITE, !cmd.out_load)
	`PNCE_ASSERT_NOW(a_port_exclusive, cmd.wr, !cmd.rd_issue)

endmodule

// ----- tb/palette_nearest_color_engine_top_tb.sv -----
`timescale 1ns / 1ps
module palette_nearest_color_engine_top_tb;
	import pnce_pkg::*;

	localparam int PALETTE_ENTRIES = 256;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [15:0] color_565;
		logic [7:0]  best_index;
	} palette_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
	logic [1:0]  s_axis_tuser = '0;  // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // color_565[15:0], best_index[23:16]

	logic [15:0]     shadow_palette [PALETTE_ENTRIES];
	palette_result_t pending_results [$];
	palette_result_t oldest_result;
	int              error_count = 0;
	int              quiet_cycles = 0;
	bit              tx_gaps_on = 1'b1;
	bit              rx_gaps_on = 1'b1;
	int              rx_hold = 0;
	int              rx_hold_req = 0;
	int              rx_hold_seen = 0;
	int              rx_stall = 0;

	palette_nearest_color_engine_top #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	function automatic int dist_term(int a, int b);
		return (a - b) * (a - b);
	endfunction

	// update the shadow palette and queue the expected result of one request
	task automatic apply_palette_request(input logic [1:0] func, input logic [7:0] idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		palette_result_t res;
		logic [15:0] c;
		int best_dist;
		int d;
		res.color_565 = '0;
		res.best_index = '0;
		case (func)
			FUNC_WRITE: begin
				if (idx < PALETTE_ENTRIES)
					shadow_palette[idx] = {r[7:3], g[7:2], b[7:3]};
			end
			FUNC_READ: begin
				if (idx < PALETTE_ENTRIES)
					res.color_565 = shadow_palette[idx];
				pending_results.push_back(res);
			end
			FUNC_SEARCH: begin
				best_dist = 32'h7fffffff;
				for (int i = 0; i < PALETTE_ENTRIES; i++) begin
					c = shadow_palette[i];
					d = dist_term(r, c[15:11]) + dist_term(g, c[10:5]) + dist_term(b, c[4:0]);
					if (d < best_dist) begin
						best_dist = d;
						res.best_index = 8'(i);
					end
				end
				res.color_565 = shadow_palette[res.best_index];
				pending_results.push_back(res);
			end
			default: ;
		endcase
	endtask

	task automatic send_request(input logic [1:0] func, input logic [7:0] idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {b, g, r, idx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		apply_palette_request(func, idx, r, g, b);
	endtask

	// random request; counted is low for an ignored func code
	task automatic send_random_request(input int write_pct, input int read_pct,
			input int search_pct, output bit counted);
		int pick;
		int sel;
		logic [15:0] c;
		logic [7:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		idx = 8'($urandom_range(0, 255));
		c = shadow_palette[$urandom_range(0, PALETTE_ENTRIES - 1)];
		r = 8'($urandom_range(0, 255));
		g = 8'($urandom_range(0, 255));
		b = 8'($urandom_range(0, 255));
		counted = 1'b1;
		if (pick < write_pct) begin
			if ($urandom_range(0, 3) == 0) begin
				// duplicate an existing color so that searches see ties
				r = {c[15:11], 3'($urandom_range(0, 7))};
				g = {c[10:5], 2'($urandom_range(0, 3))};
				b = {c[4:0], 3'($urandom_range(0, 7))};
			end
			send_request(FUNC_WRITE, idx, r, g, b);
		end else if (pick < write_pct + read_pct) begin
			send_request(FUNC_READ, idx, r, g, b);
		end else if (pick < write_pct + read_pct + search_pct) begin
			sel = $urandom_range(0, 3);
			if (sel == 0) begin
				r = {3'b0, c[15:11]};
				g = {2'b0, c[10:5]};
				b = {3'b0, c[4:0]};
			end else if (sel < 3) begin
				r = 8'($urandom_range(0, 31));
				g = 8'($urandom_range(0, 63));
				b = 8'($urandom_range(0, 31));
			end
			send_request(FUNC_SEARCH, idx, r, g, b);
		end else begin
			send_request(FUNC_UNUSED, idx, r, g, b);
			counted = 1'b0;
		end
	endtask

	task automatic send_random_run(input int n, input int write_pct, input int read_pct,
			input int search_pct);
		int done;
		bit counted;
		done = 0;
		while (done < n) begin
			send_random_request(write_pct, read_pct, search_pct, counted);
			if (counted)
				done++;
		end
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", m_axis_tdata, 0);
			end else begin
				oldest_result = pending_results.pop_front();
				if (m_axis_tdata[15:0] !== oldest_result.color_565)
					report_mismatch("color_565", m_axis_tdata[15:0], oldest_result.color_565);
				if (m_axis_tdata[23:16] !== oldest_result.best_index)
					report_mismatch("best_index", m_axis_tdata[23:16], oldest_result.best_index);
			end
		end
	end

	// receiver: random stall bursts, or a long hold requested by a test
	always @(posedge clk) begin
		if (rx_hold_req != rx_hold_seen) begin
			m_axis_tready <= 1'b0;
			rx_hold <= HOLD_CYCLES;
			rx_hold_seen <= rx_hold_req;
		end else if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_stall > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if (rx_gaps_on && $urandom_range(0, 7) == 0) begin
			m_axis_tready <= 1'b0;
			rx_stall <= $urandom_range(0, 14);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("palette_nearest_color_engine_top_tb: done, errors");
				$finish;
			end
		end
	end

	task automatic test_reset_contents();
		send_request(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0);
		send_request(FUNC_READ, 8'd255, 8'd255, 8'd255, 8'd255);
		send_request(FUNC_SEARCH, 8'd0, 8'd0, 8'd0, 8'd0);
		send_request(FUNC_SEARCH, 8'd255, 8'd255, 8'd255, 8'd255);
	endtask

	task automatic test_entry_packing();
		send_request(FUNC_WRITE, 8'd0, 8'd255, 8'd255, 8'd255);
		send_request(FUNC_WRITE, 8'd255, 8'd255, 8'd0, 8'd0);
		send_request(FUNC_WRITE, 8'd128, 8'd0, 8'd255, 8'd0);
		send_request(FUNC_WRITE, 8'd1, 8'd0, 8'd0, 8'd255);
		send_request(FUNC_WRITE, 8'd2, 8'd7, 8'd3, 8'd7);
		send_request(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0);
		send_request(FUNC_READ, 8'd255, 8'd0, 8'd0, 8'd0);
		send_request(FUNC_READ, 8'd128, 8'd0, 8'd0, 8'd0);
		send_request(FUNC_READ, 8'd1, 8'd0, 8'd0, 8'd0);
		send_request(FUNC_READ, 8'd2, 8'd0, 8'd0, 8'd0);
	endtask

	task automatic test_unused_func();
		send_request(FUNC_UNUSED, 8'd0, 8'd0, 8'd0, 8'd0);
		send_request(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0);
	endtask

	task automatic test_search_ties_and_matches();
		// fields 4/8/4 at entry 10, then a duplicate at 20: lower index must win
		send_request(FUNC_WRITE, 8'd10, 8'd32, 8'd32, 8'd32);
		send_request(FUNC_SEARCH, 8'd99, 8'd4, 8'd8, 8'd4);
		send_request(FUNC_WRITE, 8'd20, 8'd39, 8'd35, 8'd39);
		send_request(FUNC_SEARCH, 8'd0, 8'd4, 8'd8, 8'd4);
		send_request(FUNC_SEARCH, 8'd0, 8'd31, 8'd63, 8'd31);
		send_request(FUNC_SEARCH, 8'd0, 8'd255, 8'd255, 8'd255);
		wait_results_drained();
	endtask

	task automatic test_random_traffic();
		send_random_run(200, 45, 20, 30);
		wait_results_drained();
		send_random_run(200, 45, 20, 30);
		wait_results_drained();
	endtask

	task automatic test_receiver_hold();
		rx_hold_req <= rx_hold_req + 1;
		send_random_run(30, 20, 50, 25);
		wait_results_drained();
	endtask

	task automatic test_back_to_back();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		send_random_run(200, 45, 20, 30);
		wait_results_drained();
	endtask

	initial begin
		for (int i = 0; i < PALETTE_ENTRIES; i++)
			shadow_palette[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_contents();
		test_entry_packing();
		test_unused_func();
		test_search_ties_and_matches();
		test_random_traffic();
		test_receiver_hold();
		test_back_to_back();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("palette_nearest_color_engine_top_tb: done, clean");
		else
			$display("palette_nearest_color_engine_top_tb: done, errors");
		$finish;
	end

endmodule
